@@ hdl/rgbmin_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rgbmin_pkg
// Shared types and constants of the RGB 3x3 minimum filter: pixel and result
// payloads, configuration register map and the per-pixel position tag.
// ============================================================================
package rgbmin_pkg;

    // Default largest line length held in the line stores.
    localparam int MAX_WIDTH_DEF = 2048;

    // Field widths.
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;

    // Register reset values.
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // Smallest frame dimension; the window needs three rows and columns.
    localparam int MIN_DIM = 3;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // One incoming raster pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } pixel_in_t;

    // One filtered interior pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_last;
    } result_t;

    // Position flags of a pixel, decided when it is accepted.
    typedef struct packed {
        logic emit;   // pixel completes a 3x3 window of an interior pixel
        logic last;   // pixel is the final one of the frame
    } tag_t;

endpackage

@@ hdl/rgb_3x3_min_filter.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rgb_3x3_min_filter
// 3x3 per-channel minimum filter (grey-level erosion) for an RGB raster
// stream, one pixel per clock unless a held output stalls the input.
// ============================================================================
// Usage:
//   Pixels enter in raster order on in_valid / in_data; a request is taken
//   at a clock edge where in_valid is high and in_stall is low. For every
//   pixel at row y >= 2 and column x >= 2 one result leaves on out_valid /
//   out_data: the per-channel minimum over the 3x3 window centered on
//   (y-1, x-1). Border pixels produce no result. frame_last marks the result
//   caused by the final pixel of the frame.
//   An accepted request is registered in stage one while the line stores
//   are read; the window minimum then goes into the output register.
//   Throughput is one pixel per clock while no held output stalls the input,
//   set by the single read and write port of each line store.
//   When out_stall holds a pending result, stage one may still absorb pixels;
//   once it holds one that has a result, in_stall rises combinationally.
//   Reset sets the width to 640 and the height to 480 and starts a new frame;
//   the line stores are not cleared, since the first two rows of each frame
//   fill them. A write on the cfg port restarts the frame and is allowed only
//   while the pipeline is empty.
// ============================================================================
module rgb_3x3_min_filter #(
    parameter int MAX_WIDTH = rgbmin_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rgbmin_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rgbmin_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    input  rgbmin_pkg::pixel_in_t              in_data,
    output logic                               in_stall,
    output logic                               out_valid,
    output rgbmin_pkg::result_t                out_data,
    input  logic                               out_stall
);

    import rgbmin_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic               accept;
    logic [AW-1:0]      col;
    tag_t               tag;
    logic [PIXEL_W-1:0] older_rd;
    logic [PIXEL_W-1:0] newer_rd;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [PIXEL_W-1:0] older_wdata;
    logic [PIXEL_W-1:0] newer_wdata;

    // Geometry registers and raster position.
    rgbmin_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .col       (col),
        .tag       (tag)
    );

    // Line store for row y-2.
    rgbmin_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (older_wdata),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (older_rd)
    );

    // Line store for row y-1.
    rgbmin_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (newer_wdata),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (newer_rd)
    );

    // Window, minimum and output register.
    rgbmin_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .in_stall    (in_stall),
        .rd_addr     (col),
        .tag         (tag),
        .accept      (accept),
        .older_rd    (older_rd),
        .newer_rd    (newer_rd),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .older_wdata (older_wdata),
        .newer_wdata (newer_wdata),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .out_stall   (out_stall)
    );

endmodule

@@ hdl/rgbmin_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rgbmin_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ============================================================================
module rgbmin_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/rgbmin_pos.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rgbmin_pos
// Frame geometry registers and the column and row counters that locate each
// accepted pixel within its frame.
// ============================================================================
module rgbmin_pos #(
    parameter int MAX_WIDTH = rgbmin_pkg::MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rgbmin_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rgbmin_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                advance,
    output logic [CW-1:0]                       col,
    output rgbmin_pkg::tag_t                    tag
);

    import rgbmin_pkg::*;

    // Width of the width comparisons: holds both the register and MAX_WIDTH.
    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    logic [WIDTH_W-1:0]  width_reg,  width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [CW-1:0]       col_reg,    col_next;
    logic [HEIGHT_W-1:0] row_reg,    row_next;

    logic [EW-1:0]       width_ext;
    logic [EW-1:0]       eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic                last_col;
    logic                last_row;

    // Clamp the width to [3, MAX_WIDTH] and the height to at least 3.
    always_comb
    begin
        width_ext = EW'(width_reg);
        if (width_ext < EW'(MIN_DIM))
        begin
            eff_width = EW'(MIN_DIM);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            eff_width = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end

        if (height_reg < HEIGHT_W'(MIN_DIM))
        begin
            eff_height = HEIGHT_W'(MIN_DIM);
        end
        else
        begin
            eff_height = height_reg;
        end
    end

    // End-of-row and end-of-frame detection for the current position.
    assign last_col = (EW'(col_reg) + EW'(1)) >= eff_width;
    assign last_row = ({1'b0, row_reg} + (HEIGHT_W + 1)'(1)) >= {1'b0, eff_height};

    assign col      = col_reg;
    assign tag.emit = (col_reg >= CW'(2)) && (row_reg >= HEIGHT_W'(2));
    assign tag.last = last_col && last_row;

    // Register writes restart the frame; otherwise step through the raster.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
        else if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

@@ hdl/rgbmin_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rgbmin_core
// Pixel pipeline: holds the accepted pixel while the line stores are read,
// shifts the 3x3 window, takes the per-channel minimum and registers the
// result toward the output channel.
// ============================================================================
module rgbmin_core #(
    parameter int MAX_WIDTH = rgbmin_pkg::MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  rgbmin_pkg::pixel_in_t             in_data,
    output logic                              in_stall,
    input  logic [AW-1:0]                     rd_addr,
    input  rgbmin_pkg::tag_t                  tag,
    output logic                              accept,
    input  logic [rgbmin_pkg::PIXEL_W-1:0]    older_rd,
    input  logic [rgbmin_pkg::PIXEL_W-1:0]    newer_rd,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [rgbmin_pkg::PIXEL_W-1:0]    older_wdata,
    output logic [rgbmin_pkg::PIXEL_W-1:0]    newer_wdata,
    output logic                              out_valid,
    output rgbmin_pkg::result_t               out_data,
    input  logic                              out_stall
);

    import rgbmin_pkg::*;

    function automatic logic [CHAN_W-1:0] min8(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Stage one: the accepted pixel, its position and the line address.
    logic            s1_valid_reg;
    pixel_in_t       s1_pixel_reg;
    tag_t            s1_tag_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic            s1_adv;

    // Two columns to the left of the current one: [column][top, middle, bottom].
    pixel_in_t       win_reg [2][3];
    pixel_in_t       col_px  [3];
    pixel_in_t       nbr     [9];

    // Output register.
    logic            out_valid_reg;
    result_t         out_data_reg;
    result_t         result;

    // Stage one moves on unless it has a result and the output is full and held.
    assign s1_adv   = s1_valid_reg && (!s1_tag_reg.emit || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= in_data;
            s1_tag_reg   <= tag;
            s1_addr_reg  <= rd_addr;
        end
    end

    // Current column: row y-2 and row y-1 from the stores, row y from the input.
    assign col_px[0] = pixel_in_t'(older_rd);
    assign col_px[1] = pixel_in_t'(newer_rd);
    assign col_px[2] = s1_pixel_reg;

    // Line store update: the row above ages, the current pixel becomes newer.
    assign wr_en       = s1_adv;
    assign wr_addr     = s1_addr_reg;
    assign older_wdata = newer_rd;
    assign newer_wdata = s1_pixel_reg;

    // Window shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[k][r] <= '0;
                end
            end
        end
        else if (s1_adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[0][r] <= win_reg[1][r];
                win_reg[1][r] <= col_px[r];
            end
        end
    end

    // Per-channel minimum over the nine pixels of the window.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            nbr[r]     = win_reg[0][r];
            nbr[r + 3] = win_reg[1][r];
            nbr[r + 6] = col_px[r];
        end
        result.out_red   = nbr[0].in_red;
        result.out_green = nbr[0].in_green;
        result.out_blue  = nbr[0].in_blue;
        for (int i = 1; i < 9; i++)
        begin
            result.out_red   = min8(result.out_red,   nbr[i].in_red);
            result.out_green = min8(result.out_green, nbr[i].in_green);
            result.out_blue  = min8(result.out_blue,  nbr[i].in_blue);
        end
        result.frame_last = s1_tag_reg.last;
    end

    // Output register: loads a result, empties when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_tag_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_tag_reg.emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/rgbmin_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rgbmin_checker
// Port-level checks of the minimum filter: output hold under stall, input
// back-pressure only from a held output, and pipeline latency.
// ============================================================================
module rgbmin_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input rgbmin_pkg::result_t   out_data,
    input logic                  out_stall
);

    // A stalled result stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output result changed while stalled");

    // The input is held back only while a result waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output");

    // A new result follows an accepted request through stage one and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching request");

endmodule

bind rgb_3x3_min_filter rgbmin_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
);
